// File: design/lzss_pkg.sv
// Shared constants, types and helper functions of the LZSS encoder core.
package lzss_pkg;

    localparam int HIST_LEN  = 1024;
    localparam int LOOKAHEAD = 16;
    localparam int DICT_W    = $clog2(HIST_LEN);
    localparam int LA_IDX_W  = $clog2(LOOKAHEAD);
    localparam int LEN_W     = 5;
    localparam int GRP       = 32;
    localparam int GRP_W     = $clog2(GRP);
    localparam int NGRP      = HIST_LEN / GRP;
    localparam int NGRP_W    = $clog2(NGRP);

    function automatic int bits_for(input int v);
        int w;
        int x;
        w = 0;
        x = v;
        while (x != 0) begin
            w = w + 1;
            x = x >> 1;
        end
        return w;
    endfunction

    // shortest match that is worth a reference token
    localparam int REF_WEIGHT  = 1 + bits_for(HIST_LEN) + bits_for(LOOKAHEAD);
    localparam int REF_MIN_LEN = REF_WEIGHT / 9 + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_POP, S_LOAD, S_STEP, S_ORW, S_CHK,
        S_FG, S_FW, S_OUT, S_WAIT, S_FPOP, S_CLR
    } t_state;

    typedef struct packed {
        logic              clear;
        logic              shift;
        logic [7:0]        shift_in;
        logic              probe_load;
        logic              step;
        logic [7:0]        cmp;
        logic              best_latch;
        logic [NGRP_W-1:0] sel;
    } t_chain_ctrl;

    function automatic logic [GRP_W-1:0] first_one(input logic [GRP-1:0] v);
        logic [GRP_W-1:0] r;
        r = '0;
        for (int i = GRP - 1; i >= 0; i--) begin
            if (v[i]) r = GRP_W'(i);
        end
        return r;
    endfunction

    function automatic logic [NGRP_W-1:0] first_grp(input logic [NGRP-1:0] v);
        logic [NGRP_W-1:0] r;
        r = '0;
        for (int i = NGRP - 1; i >= 0; i--) begin
            if (v[i]) r = NGRP_W'(i);
        end
        return r;
    endfunction

endpackage

// File: design/lzss_cell.sv
// One history cell: a window byte, a probe byte moving down the chain, match flags.
module lzss_cell (
    input  logic                  i_clk,
    input  lzss_pkg::t_chain_ctrl i_ctrl,
    input  logic [7:0]            i_shift_in,
    input  logic [7:0]            i_probe_in,
    input  logic                  i_probe_in_v,
    output logic [7:0]            o_hist,
    output logic [7:0]            o_probe,
    output logic                  o_probe_v,
    output logic                  o_alive,
    output logic                  o_best
);
    logic [7:0] r_hist;
    logic [7:0] r_probe;
    logic       r_probe_v;
    logic       r_alive;
    logic       r_best;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_hist <= '0;
        end else if (i_ctrl.shift) begin
            r_hist <= i_shift_in;
        end
        if (i_ctrl.probe_load) begin
            r_probe   <= r_hist;
            r_probe_v <= 1'b1;
            r_alive   <= 1'b1;
        end else if (i_ctrl.step) begin
            r_probe   <= i_probe_in;
            r_probe_v <= i_probe_in_v;
            r_alive   <= r_alive & r_probe_v & (r_probe == i_ctrl.cmp);
        end
        if (i_ctrl.best_latch) begin
            r_best <= r_alive;
        end
    end

    assign o_hist    = r_hist;
    assign o_probe   = r_probe;
    assign o_probe_v = r_probe_v;
    assign o_alive   = r_alive;
    assign o_best    = r_best;
endmodule

// File: design/lzss_chain.sv
// Row of history cells with group reductions of the match flags.
module lzss_chain (
    input  logic                          i_clk,
    input  lzss_pkg::t_chain_ctrl         i_ctrl,
    output logic [lzss_pkg::NGRP-1:0]     o_alive_grp,
    output logic [lzss_pkg::NGRP-1:0]     o_best_grp,
    output logic [lzss_pkg::GRP-1:0]      o_best_word
);
    logic [7:0] w_hist  [lzss_pkg::HIST_LEN];
    logic [7:0] w_probe [lzss_pkg::HIST_LEN];
    logic [lzss_pkg::HIST_LEN-1:0] w_pv;
    logic [lzss_pkg::HIST_LEN-1:0] w_alive;
    logic [lzss_pkg::HIST_LEN-1:0] w_best;

    for (genvar i = 0; i < lzss_pkg::HIST_LEN; i++) begin : g_cell
        logic [7:0] w_sin;
        logic [7:0] w_pin;
        logic       w_pinv;
        if (i == lzss_pkg::HIST_LEN - 1) begin : g_end
            assign w_sin  = i_ctrl.shift_in;
            assign w_pin  = '0;
            assign w_pinv = 1'b0;
        end else begin : g_mid
            assign w_sin  = w_hist[i+1];
            assign w_pin  = w_probe[i+1];
            assign w_pinv = w_pv[i+1];
        end
        lzss_cell u_cell (
            .i_clk        (i_clk),
            .i_ctrl       (i_ctrl),
            .i_shift_in   (w_sin),
            .i_probe_in   (w_pin),
            .i_probe_in_v (w_pinv),
            .o_hist       (w_hist[i]),
            .o_probe      (w_probe[i]),
            .o_probe_v    (w_pv[i]),
            .o_alive      (w_alive[i]),
            .o_best       (w_best[i])
        );
    end

    for (genvar g = 0; g < lzss_pkg::NGRP; g++) begin : g_grp
        assign o_alive_grp[g] = |w_alive[g*lzss_pkg::GRP +: lzss_pkg::GRP];
        assign o_best_grp[g]  = |w_best[g*lzss_pkg::GRP +: lzss_pkg::GRP];
    end

    assign o_best_word = w_best[i_ctrl.sel*lzss_pkg::GRP +: lzss_pkg::GRP];
endmodule

// File: design/lzss_sliding_window_encoder_core.sv
// Top level of the LZSS sliding-window token encoder.
// Input stream (s_axis): one raw byte per request in tdata[7:0]; tlast marks the
// final byte of a stream and starts the flush of the lookahead.
// Output stream (m_axis): one token per request. tuser is 1 for a back reference,
// 0 for a literal; tlast marks the final token caused by one input byte.
// A byte that completes a refill starts a match search over all 1024 history
// positions, run in a row of cells: the lookahead is compared one byte per step,
// each step passing S_STEP, S_ORW and S_CHK, while probe bytes move one cell per step.
// A decision runs S_LOAD, then the steps until no cell matches or all lookahead bytes
// are compared, then S_FG, S_FW and S_OUT, and waits in S_WAIT for the output register.
// A byte that causes no token leaves the core idle. At end of stream each flush
// decision is followed by its pops in S_FPOP, one per byte consumed, and S_CLR
// returns the state to its reset values.
// s_axis_tready is high only while the core is idle; a stalled receiver holds
// the token in the output register and the core waits.
// Reset (i_rst_n low, synchronous) empties the window to zero bytes and the
// lookahead, and drops the output valid signal.
module lzss_sliding_window_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] literal_byte, [17:8] match_offset,
                                        // [22:18] match_length, [23] zero
    output logic        m_axis_tuser,   // is_reference
    output logic        m_axis_tlast    // last_token
);
    localparam int LW = lzss_pkg::LEN_W;

    lzss_pkg::t_state      r_state;
    lzss_pkg::t_state      n_state;
    lzss_pkg::t_chain_ctrl w_ctrl;

    logic [7:0]                     r_look [lzss_pkg::LOOKAHEAD];
    logic [LW-1:0]                  r_len;
    logic [LW-1:0]                  r_bta;
    logic [lzss_pkg::LA_IDX_W-1:0]  r_m;
    logic [LW-1:0]                  r_blen;
    logic [LW-1:0]                  r_cnt;
    logic                           r_eos;
    logic [lzss_pkg::NGRP-1:0]      r_alive_grp;
    logic [lzss_pkg::NGRP_W-1:0]    r_grp;
    logic [lzss_pkg::DICT_W-1:0]    r_pos;
    logic                           r_ovalid;
    logic                           r_oref;
    logic [7:0]                     r_olit;
    logic [lzss_pkg::DICT_W-1:0]    r_ooff;
    logic [LW-1:0]                  r_olen;
    logic                           r_olast;

    logic [lzss_pkg::NGRP-1:0] w_alive_grp;
    logic [lzss_pkg::NGRP-1:0] w_best_grp;
    logic [lzss_pkg::GRP-1:0]  w_best_word;

    logic          w_in_acc;
    logic          w_out_acc;
    logic          w_full;
    logic [LW-1:0] w_len_n;
    logic [LW-1:0] w_bta_n;
    logic [LW-1:0] w_m1;
    logic          w_is_ref;
    logic [LW-1:0] w_k;

    assign w_in_acc  = s_axis_tvalid && s_axis_tready;
    assign w_out_acc = r_ovalid && m_axis_tready;
    assign w_full    = (r_len == LW'(lzss_pkg::LOOKAHEAD));
    assign w_len_n   = w_full ? r_len : r_len + LW'(1);
    assign w_bta_n   = (r_bta != '0) ? r_bta - LW'(1) : r_bta;
    assign w_m1      = LW'(r_m) + LW'(1);
    assign w_is_ref  = (r_blen >= LW'(lzss_pkg::REF_MIN_LEN));
    assign w_k       = w_is_ref ? r_blen : LW'(1);

    lzss_chain u_chain (
        .i_clk       (i_clk),
        .i_ctrl      (w_ctrl),
        .o_alive_grp (w_alive_grp),
        .o_best_grp  (w_best_grp),
        .o_best_word (w_best_word)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            lzss_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    if (!s_axis_tlast) begin
                        if (w_bta_n == '0 && w_len_n != '0) n_state = lzss_pkg::S_LOAD;
                    end else if (w_len_n == LW'(lzss_pkg::LOOKAHEAD) && w_bta_n != '0) begin
                        n_state = lzss_pkg::S_POP;
                    end else begin
                        n_state = lzss_pkg::S_LOAD;
                    end
                end
            end
            lzss_pkg::S_POP:  if (r_bta == LW'(1)) n_state = lzss_pkg::S_LOAD;
            lzss_pkg::S_LOAD: n_state = lzss_pkg::S_STEP;
            lzss_pkg::S_STEP: n_state = lzss_pkg::S_ORW;
            lzss_pkg::S_ORW:  n_state = lzss_pkg::S_CHK;
            lzss_pkg::S_CHK: begin
                if (|r_alive_grp && w_m1 != r_len) n_state = lzss_pkg::S_STEP;
                else n_state = lzss_pkg::S_FG;
            end
            lzss_pkg::S_FG:   n_state = lzss_pkg::S_FW;
            lzss_pkg::S_FW:   n_state = lzss_pkg::S_OUT;
            lzss_pkg::S_OUT:  n_state = lzss_pkg::S_WAIT;
            lzss_pkg::S_WAIT: begin
                if (w_out_acc) n_state = r_eos ? lzss_pkg::S_FPOP : lzss_pkg::S_IDLE;
            end
            lzss_pkg::S_FPOP: begin
                if (r_cnt == LW'(1)) begin
                    n_state = (r_len == LW'(1)) ? lzss_pkg::S_CLR : lzss_pkg::S_LOAD;
                end
            end
            lzss_pkg::S_CLR:  n_state = lzss_pkg::S_IDLE;
            default:          n_state = lzss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready     = (r_state == lzss_pkg::S_IDLE);
        w_ctrl            = '0;
        w_ctrl.shift_in   = r_look[0];
        w_ctrl.cmp        = r_look[r_m];
        w_ctrl.sel        = r_grp;
        case (r_state)
            lzss_pkg::S_IDLE: w_ctrl.shift      = w_in_acc && w_full;
            lzss_pkg::S_POP:  w_ctrl.shift      = 1'b1;
            lzss_pkg::S_LOAD: w_ctrl.probe_load = 1'b1;
            lzss_pkg::S_STEP: w_ctrl.step       = 1'b1;
            lzss_pkg::S_CHK:  w_ctrl.best_latch = |r_alive_grp;
            lzss_pkg::S_FPOP: w_ctrl.shift      = 1'b1;
            lzss_pkg::S_CLR:  w_ctrl.clear      = 1'b1;
            default:          w_ctrl.shift      = 1'b0;
        endcase
        if (!i_rst_n) w_ctrl.clear = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lzss_pkg::S_IDLE;
            r_len    <= '0;
            r_bta    <= LW'(lzss_pkg::LOOKAHEAD);
            r_eos    <= 1'b0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < lzss_pkg::LOOKAHEAD; i++) r_look[i] <= '0;
        end else begin
            r_state <= n_state;
            if (w_out_acc) r_ovalid <= 1'b0;
            case (r_state)
                lzss_pkg::S_IDLE: begin
                    if (w_in_acc) begin
                        r_eos <= s_axis_tlast;
                        r_bta <= w_bta_n;
                        r_len <= w_len_n;
                        if (w_full) begin
                            for (int i = 0; i < lzss_pkg::LOOKAHEAD - 1; i++) begin
                                r_look[i] <= r_look[i+1];
                            end
                            r_look[lzss_pkg::LOOKAHEAD-1] <= s_axis_tdata;
                        end else begin
                            r_look[r_len[lzss_pkg::LA_IDX_W-1:0]] <= s_axis_tdata;
                        end
                    end
                end
                lzss_pkg::S_POP, lzss_pkg::S_FPOP: begin
                    for (int i = 0; i < lzss_pkg::LOOKAHEAD - 1; i++) r_look[i] <= r_look[i+1];
                    r_look[lzss_pkg::LOOKAHEAD-1] <= '0;
                    r_len <= r_len - LW'(1);
                    if (r_state == lzss_pkg::S_POP) r_bta <= r_bta - LW'(1);
                    else r_cnt <= r_cnt - LW'(1);
                end
                lzss_pkg::S_LOAD: begin
                    r_m    <= '0;
                    r_blen <= '0;
                end
                lzss_pkg::S_ORW:  r_alive_grp <= w_alive_grp;
                lzss_pkg::S_CHK: begin
                    if (|r_alive_grp) begin
                        r_blen <= w_m1;
                        r_m    <= r_m + lzss_pkg::LA_IDX_W'(1);
                    end
                end
                lzss_pkg::S_FG:   r_grp <= lzss_pkg::first_grp(w_best_grp);
                lzss_pkg::S_FW:   r_pos <= {r_grp, lzss_pkg::first_one(w_best_word)};
                lzss_pkg::S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_oref   <= w_is_ref;
                    r_olit   <= w_is_ref ? 8'h00 : r_look[0];
                    r_ooff   <= w_is_ref ? r_pos : '0;
                    r_olen   <= w_is_ref ? r_blen : '0;
                    r_olast  <= r_eos ? (r_len == w_k) : 1'b1;
                    r_cnt    <= w_k;
                    if (!r_eos) r_bta <= w_k;
                end
                lzss_pkg::S_CLR: begin
                    r_len <= '0;
                    r_bta <= LW'(lzss_pkg::LOOKAHEAD);
                    r_eos <= 1'b0;
                    for (int i = 0; i < lzss_pkg::LOOKAHEAD; i++) r_look[i] <= '0;
                end
                default: r_eos <= r_eos;
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_olen, r_ooff, r_olit};
    assign m_axis_tuser  = r_oref;
    assign m_axis_tlast  = r_olast;
endmodule
